// File: rtl/cpd_pkg.sv
`timescale 1ns / 1ps

package cpd_pkg;

    localparam int LENGTH_BITS = 16;

    // Largest length the length counters can represent
    localparam logic [16:0] LENGTH_LIMIT = 17'((64'd1 << LENGTH_BITS) - 64'd1);

    localparam logic [15:0] CRC_POLY      = 16'h8408;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;
    localparam logic [15:0] MIN_LENGTH    = 16'd2;

    typedef enum logic [1:0] {
        PH_TAG    = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_MID      = 2'd0,
        VERDICT_GOOD     = 2'd1,
        VERDICT_MISMATCH = 2'd2,
        VERDICT_BAD_LEN  = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  packet_tag;
        logic [15:0] packet_length;
        verdict_t    verdict;
        logic        frame_end;
    } result_t;

endpackage

// File: rtl/crc_checked_packet_deframer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// config    in         cfg_we                cfg_data (max_payload)
// input     in         in_valid / in_stall   rx_byte
// output    out        out_valid / out_stall payload_byte, byte_index, packet_tag,
//                                            packet_length, verdict, frame_end
//
// One item per cycle sustained while out_stall is low; each result is registered in the output
// register when its item steps from the input register through frame logic with byte-wide CRC.
// Header bytes give no result, except a bad length, reported on the last header byte.
// Reset clears the frame state and sets max_payload to 1024; no clearing pass.
// out_stall holds the output register, and the input register fills one more item
// before in_stall rises.
module crc_checked_packet_deframer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic [15:0] byte_index,
    output logic [7:0]  packet_tag,
    output logic [15:0] packet_length,
    output logic [1:0]  verdict,
    output logic        frame_end
);

    logic [15:0]      max_payload_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    cpd_pkg::result_t out_reg;

    logic             advance;
    logic             step;
    logic             res_valid;
    cpd_pkg::result_t res;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= cpd_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            max_payload_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    cpd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data        (in_byte_reg),
        .max_payload (max_payload_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = out_reg.payload_byte;
    assign byte_index    = out_reg.byte_index;
    assign packet_tag    = out_reg.packet_tag;
    assign packet_length = out_reg.packet_length;
    assign verdict       = out_reg.verdict;
    assign frame_end     = out_reg.frame_end;

    a_bad_len_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == cpd_pkg::VERDICT_BAD_LEN
        |-> payload_byte == 8'h00 && byte_index == 16'h0000)
        else $error("bad-length item carries payload data");

    a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !step)
        else $error("frame state advanced while output held");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("buffered input item dropped");

endmodule

// File: rtl/cpd_crc_byte.sv
`timescale 1ns / 1ps

// One byte of reflected CRC-16, all eight bit steps unrolled.
module cpd_crc_byte
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ cpd_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// File: rtl/cpd_parser.sv
`timescale 1ns / 1ps

// Frame state and per-item result. State advances on step.
module cpd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data,
    input  logic [15:0]       max_payload,
    output logic              res_valid,
    output cpd_pkg::result_t  res
);

    cpd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] seen_reg, seen_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  trailer_reg, trailer_next;

    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [16:0] idx_plus2;
    logic        bad_len;

    cpd_crc_byte u_crc
    (
        .crc_in  (crc_reg),
        .data    (data),
        .crc_out (crc_upd)
    );

    assign len_full  = {data, length_reg[7:0]};
    assign idx_plus2 = {1'b0, seen_reg} + 17'd2;
    assign bad_len   = (len_full < cpd_pkg::MIN_LENGTH) || (len_full > max_payload)
                       || ({1'b0, len_full} > cpd_pkg::LENGTH_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= cpd_pkg::PH_TAG;
            tag_reg     <= 8'h00;
            length_reg  <= 16'h0000;
            seen_reg    <= 16'h0000;
            crc_reg     <= cpd_pkg::CRC_INIT;
            trailer_reg <= 8'h00;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tag_reg     <= tag_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            crc_reg     <= crc_next;
            trailer_reg <= trailer_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        crc_next     = crc_reg;
        trailer_next = trailer_reg;

        res_valid         = 1'b0;
        res.payload_byte  = data;
        res.byte_index    = seen_reg;
        res.packet_tag    = tag_reg;
        res.packet_length = length_reg;
        res.verdict       = cpd_pkg::VERDICT_MID;
        res.frame_end     = 1'b0;

        unique case (phase_reg)
            cpd_pkg::PH_TAG:
            begin
                tag_next     = data;
                length_next  = 16'h0000;
                seen_next    = 16'h0000;
                crc_next     = cpd_pkg::CRC_INIT;
                trailer_next = 8'h00;
                phase_next   = cpd_pkg::PH_LEN_LO;
            end
            cpd_pkg::PH_LEN_LO:
            begin
                length_next = {8'h00, data};
                phase_next  = cpd_pkg::PH_LEN_HI;
            end
            cpd_pkg::PH_LEN_HI:
            begin
                length_next = len_full;
                if (bad_len)
                begin
                    phase_next        = cpd_pkg::PH_TAG;
                    res_valid         = 1'b1;
                    res.payload_byte  = 8'h00;
                    res.byte_index    = 16'h0000;
                    res.packet_length = len_full;
                    res.verdict       = cpd_pkg::VERDICT_BAD_LEN;
                    res.frame_end     = 1'b1;
                end
                else
                begin
                    seen_next  = 16'h0000;
                    phase_next = cpd_pkg::PH_DATA;
                end
            end
            cpd_pkg::PH_DATA:
            begin
                res_valid = 1'b1;
                if (idx_plus2 < {1'b0, length_reg})
                begin
                    crc_next  = crc_upd;
                    seen_next = seen_reg + 16'd1;
                end
                else if (idx_plus2 == {1'b0, length_reg})
                begin
                    trailer_next = data;
                    seen_next    = seen_reg + 16'd1;
                end
                else
                begin
                    // last trailer byte closes the frame
                    phase_next    = cpd_pkg::PH_TAG;
                    res.frame_end = 1'b1;
                    res.verdict   = ((~crc_reg) == {data, trailer_reg})
                                    ? cpd_pkg::VERDICT_GOOD : cpd_pkg::VERDICT_MISMATCH;
                end
            end
            default:
            begin
                phase_next = cpd_pkg::PH_TAG;
            end
        endcase
    end

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == cpd_pkg::PH_DATA |-> seen_reg < length_reg)
        else $error("payload index ran past header length");

    a_end_returns_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.frame_end |=> phase_reg == cpd_pkg::PH_TAG)
        else $error("frame closed without returning to tag wait");

    a_data_length_ok: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == cpd_pkg::PH_DATA |-> length_reg >= cpd_pkg::MIN_LENGTH)
        else $error("payload phase entered with short length");

    a_end_matches_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.frame_end == (res.verdict != cpd_pkg::VERDICT_MID)))
        else $error("frame_end and verdict disagree");

endmodule
